// ===== hdl/vlsd_pkg.sv =====
package vlsd_pkg;

    localparam int DEF_MAX_LABELS    = 16;
    localparam int DEF_MAX_POSITIONS = 64;

    localparam int SCORE_W = 32;
    localparam int LABEL_W = 4;
    localparam int POS_W   = 6;
    localparam int NL_W    = 5;

    localparam logic       CMD_TRANS = 1'b0;
    localparam logic       CMD_STATE = 1'b1;
    localparam logic [NL_W-1:0] LABELS_RST = 5'd16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic trans_wr;
        logic capture;
        logic scan_issue;
        logic fin;
        logic upd;
        logic pos_step;
        logic emit_load;
        logic bl_step;
        logic finish;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic lab_ok;
        logic idx_last;
        logic eos;
        logic t_zero;
    } t_dp_status;

    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] s;
        logic signed [SCORE_W-1:0] r;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            r = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            r = s[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/vlsd_datapath.sv =====
module vlsd_datapath #(
    parameter int MAX_LABELS    = vlsd_pkg::DEF_MAX_LABELS,
    parameter int MAX_POSITIONS = vlsd_pkg::DEF_MAX_POSITIONS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [vlsd_pkg::NL_W-1:0]             i_cfg_data,
    input  logic [vlsd_pkg::LABEL_W-1:0]          i_from_label,
    input  logic [vlsd_pkg::LABEL_W-1:0]          i_to_label,
    input  logic signed [vlsd_pkg::SCORE_W-1:0]   i_score,
    input  logic                                  i_end_of_sequence,
    input  vlsd_pkg::t_dp_cmd                     i_cmd,
    output vlsd_pkg::t_dp_status                  o_status,
    output logic [vlsd_pkg::POS_W-1:0]            o_position,
    output logic [vlsd_pkg::LABEL_W-1:0]          o_label,
    output logic signed [vlsd_pkg::SCORE_W-1:0]   o_best_score,
    output logic                                  o_last,
    output logic                                  o_overflow
);
    localparam int LW  = $clog2(MAX_LABELS);
    localparam int TW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CW  = $clog2(MAX_POSITIONS + 1);
    localparam int CAP = (MAX_LABELS < 16) ? MAX_LABELS : 16;
    localparam int SW  = vlsd_pkg::SCORE_W;
    localparam int NW  = vlsd_pkg::NL_W;

    logic signed [SW-1:0] trans_mem [2**(2*LW)];
    logic signed [SW-1:0] path_mem  [2**(LW+1)];
    logic [LW-1:0]        bl_mem    [2**(TW+LW)];

    logic [NW-1:0]        r_num;
    logic [CW-1:0]        r_cnt;
    logic                 r_ovf;
    logic [LW-1:0]        r_idx;
    logic [vlsd_pkg::LABEL_W-1:0] r_to;
    logic signed [SW-1:0] r_s;
    logic                 r_eos;
    logic signed [SW-1:0] r_prd, r_trd, r_c, r_mx, r_best;
    logic                 r_p1_v, r_p1_fin, r_p2_v;
    logic [LW-1:0]        r_p1_idx, r_p2_idx, r_arg, r_lab, r_bl;
    logic [TW-1:0]        r_t;

    logic [NW-1:0]        l_eff;
    logic [LW-1:0]        to_idx;
    logic                 full, lab_ok, lab_last, trans_ok;
    logic signed [SW-1:0] upd_val;

    always_comb begin
        if (r_num == '0) begin
            l_eff = NW'(1);
        end else if (r_num > NW'(CAP)) begin
            l_eff = NW'(CAP);
        end else begin
            l_eff = r_num;
        end
    end

    assign to_idx   = LW'(r_to);
    assign full     = (r_cnt >= CW'(MAX_POSITIONS));
    assign lab_ok   = (NW'(r_to) < l_eff);
    assign lab_last = (NW'(r_to) == l_eff - NW'(1));
    assign trans_ok = (32'(i_from_label) < 32'(MAX_LABELS)) &&
                      (32'(i_to_label) < 32'(MAX_LABELS));
    assign upd_val  = (r_cnt == '0) ? r_s : vlsd_pkg::sat_add(r_mx, r_s);

    assign o_status.full     = full;
    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.lab_ok   = lab_ok;
    assign o_status.idx_last = (NW'(r_idx) == l_eff - NW'(1));
    assign o_status.eos      = r_eos;
    assign o_status.t_zero   = (r_t == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.trans_wr && trans_ok) begin
            trans_mem[{LW'(i_from_label), LW'(i_to_label)}] <= i_score;
        end
        r_trd <= trans_mem[{r_idx, to_idx}];
    end

    // bank by position parity, previous bank is the other one
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            path_mem[{r_cnt[0], to_idx}] <= upd_val;
        end
        r_prd <= path_mem[{~r_cnt[0], r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && (r_cnt != '0)) begin
            bl_mem[{TW'(r_cnt), to_idx}] <= r_arg;
        end
        r_bl <= bl_mem[{r_t, r_lab}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num    <= vlsd_pkg::LABELS_RST;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_p1_fin <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_data;
            end
            if (i_cmd.scan_issue) begin
                r_idx <= o_status.idx_last ? '0 : r_idx + LW'(1);
            end
            r_p1_v   <= i_cmd.scan_issue;
            r_p1_fin <= i_cmd.fin;
            r_p2_v   <= r_p1_v;
            if (i_cmd.pos_step) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else if (r_eos || (lab_ok && lab_last)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_to  <= i_to_label;
            r_s   <= i_score;
            r_eos <= i_end_of_sequence;
        end
        r_p1_idx <= r_idx;
        r_c      <= vlsd_pkg::sat_add(r_prd, r_p1_fin ? '0 : r_trd);
        r_p2_idx <= r_p1_idx;
        // strict compare keeps the lowest index on ties
        if (r_p2_v && ((r_p2_idx == '0) || (r_c > r_mx))) begin
            r_mx  <= r_c;
            r_arg <= r_p2_idx;
        end
        if (i_cmd.emit_load) begin
            r_t    <= TW'(r_cnt - CW'(1));
            r_lab  <= r_arg;
            r_best <= r_mx;
        end else if (i_cmd.bl_step) begin
            r_t   <= r_t - TW'(1);
            r_lab <= r_bl;
        end
    end

    assign o_position   = vlsd_pkg::POS_W'(r_t);
    assign o_label      = vlsd_pkg::LABEL_W'(r_lab);
    assign o_best_score = r_best;
    assign o_last       = (r_t == '0);
    assign o_overflow   = r_ovf;

endmodule

// ===== hdl/vlsd_ctrl.sv =====
module vlsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_cmd,
    input  logic                 i_out_ready,
    input  vlsd_pkg::t_dp_status i_status,
    output vlsd_pkg::t_dp_cmd    o_dp_cmd,
    output logic                 o_in_ready,
    output logic                 o_out_valid
);
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CHECK   = 13'b0000000000010,
        S_SCAN    = 13'b0000000000100,
        S_DRAIN1  = 13'b0000000001000,
        S_DRAIN2  = 13'b0000000010000,
        S_UPD     = 13'b0000000100000,
        S_POS     = 13'b0000001000000,
        S_FSCAN   = 13'b0000010000000,
        S_FDRAIN1 = 13'b0000100000000,
        S_FDRAIN2 = 13'b0001000000000,
        S_LOAD    = 13'b0010000000000,
        S_EMIT    = 13'b0100000000000,
        S_BLWAIT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.capture = 1'b1;
                    if (i_cmd == vlsd_pkg::CMD_STATE) begin
                        n_state = S_CHECK;
                    end else begin
                        o_dp_cmd.trans_wr = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (!i_status.full && i_status.lab_ok) begin
                    n_state = i_status.cnt_zero ? S_UPD : S_SCAN;
                end else begin
                    n_state = S_POS;
                end
            end
            S_SCAN: begin
                o_dp_cmd.scan_issue = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_UPD;
            S_UPD: begin
                o_dp_cmd.upd = 1'b1;
                n_state = S_POS;
            end
            S_POS: begin
                o_dp_cmd.pos_step = 1'b1;
                n_state = i_status.eos ? S_FSCAN : S_IDLE;
            end
            S_FSCAN: begin
                o_dp_cmd.scan_issue = 1'b1;
                o_dp_cmd.fin = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_FDRAIN1;
                end
            end
            S_FDRAIN1: n_state = S_FDRAIN2;
            S_FDRAIN2: n_state = S_LOAD;
            S_LOAD: begin
                o_dp_cmd.emit_load = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_status.t_zero) begin
                        o_dp_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_BLWAIT;
                    end
                end
            end
            S_BLWAIT: begin
                o_dp_cmd.bl_step = 1'b1;
                n_state = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

// ===== hdl/viterbi_label_sequence_decoder.sv =====
// channel   direction  handshake              payload
// input     in         i_valid / i_ready      i_cmd i_from_label i_to_label i_score
//                                             i_end_of_sequence
// output    out        o_valid / i_out_ready  o_position o_label o_best_score o_last
//                                             o_overflow
// config    in         i_cfg_we               i_cfg_data (label count)
//
// a transition item is written from the idle state; a state item runs a predecessor scan
// that reads one path score and one transition per cycle from memory
// the end item adds a final scan, then a trace back that emits one decoded position at a time
// reset is synchronous active low and clears control state only; tables need no clear
// one item is in flight at a time; a stalled output holds the trace back
module viterbi_label_sequence_decoder #(
    parameter int MAX_LABELS    = vlsd_pkg::DEF_MAX_LABELS,
    parameter int MAX_POSITIONS = vlsd_pkg::DEF_MAX_POSITIONS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vlsd_pkg::NL_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                i_ready,
    input  logic                                i_cmd,
    input  logic [vlsd_pkg::LABEL_W-1:0]        i_from_label,
    input  logic [vlsd_pkg::LABEL_W-1:0]        i_to_label,
    input  logic signed [vlsd_pkg::SCORE_W-1:0] i_score,
    input  logic                                i_end_of_sequence,
    output logic                                o_valid,
    input  logic                                i_out_ready,
    output logic [vlsd_pkg::POS_W-1:0]          o_position,
    output logic [vlsd_pkg::LABEL_W-1:0]        o_label,
    output logic signed [vlsd_pkg::SCORE_W-1:0] o_best_score,
    output logic                                o_last,
    output logic                                o_overflow
);
    vlsd_pkg::t_dp_cmd    dp_cmd;
    vlsd_pkg::t_dp_status dp_status;

    vlsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_dp_cmd    (dp_cmd),
        .o_in_ready  (i_ready),
        .o_out_valid (o_valid)
    );

    vlsd_datapath #(
        .MAX_LABELS    (MAX_LABELS),
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_from_label      (i_from_label),
        .i_to_label        (i_to_label),
        .i_score           (i_score),
        .i_end_of_sequence (i_end_of_sequence),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .o_position        (o_position),
        .o_label           (o_label),
        .o_best_score      (o_best_score),
        .o_last            (o_last),
        .o_overflow        (o_overflow)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && i_ready))
        else $error("input ready while a result is shown");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_ready && o_last) |=> i_ready)
        else $error("not idle after the last result");

    a_pos_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_ready && !o_last) |=> ##1
            (o_valid && o_position == 6'($past(o_position, 2) - 6'd1)))
        else $error("trace back position did not step down");

endmodule
